// ===== sv/rqpb_pkg.sv =====
// ----------------------------------------------------------------------------
// rqpb_pkg
// Shared types and constants of the ring queue with priority bypass.
// ----------------------------------------------------------------------------
package rqpb_pkg;

  localparam int PRIORITY_BITS = 8;
  localparam int PAYLOAD_BITS  = 32;
  localparam int CNT_W         = 5;   // occupancy, capacity and ring pointers
  localparam int CFG_W         = 8;   // widest configuration register

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_CAP       = 1'b1
  } reg_index_t;

  typedef struct packed {
    mode_t                    mode;
    logic [PRIORITY_BITS-1:0] in_priority;
    logic [PAYLOAD_BITS-1:0]  in_payload;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic [PRIORITY_BITS-1:0] out_priority;
    logic [PAYLOAD_BITS-1:0]  out_payload;
    logic                     took_urgent;
    logic [CNT_W-1:0]         occupancy;
  } out_item_t;

endpackage

// ===== sv/ring_queue_priority_bypass_core.sv =====
// ----------------------------------------------------------------------------
// ring_queue_priority_bypass_core
// Bounded ring queue of (priority, payload) items with a pop that takes the
// oldest item at or above a threshold ahead of older ones.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Handshake
//  request   start, busy, in_item           taken when start && !busy
//  result    out_strobe, out_result         valid for one cycle, no stall
//  config    cfg_we, cfg_index, cfg_data    written when cfg_we is high
//
// A full push or an empty pop answers in the cycle after the request. A push
// writes its item, then subtracts the capacity from the tail while it wraps.
// A pop reads one RAM slot per cycle; with a priority hit behind the head,
// each older item is read and written once. A pop also first subtracts the
// capacity from the head while the head is not below it after the capacity
// shrank. busy drops in the cycle the result is on the ports, so a new
// request can be taken in that cycle. Reset clears the head and tail pointers
// and the count and sets the threshold to 128 and the capacity to 16; the RAM
// is not cleared. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module ring_queue_priority_bypass_core #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  rqpb_pkg::in_item_t            in_item,
  output logic                          out_strobe,
  output rqpb_pkg::out_item_t           out_result,
  input  logic                          cfg_we,
  input  rqpb_pkg::reg_index_t          cfg_index,
  input  logic [rqpb_pkg::CFG_W-1:0]    cfg_data
);

  localparam int AW      = $clog2(DEPTH);
  localparam int ITEM_W  = rqpb_pkg::PRIORITY_BITS + rqpb_pkg::PAYLOAD_BITS;
  localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
  localparam int CW      = rqpb_pkg::CNT_W;
  localparam int PB      = rqpb_pkg::PRIORITY_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NORM,
    ST_SRCH,
    ST_SHIFT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [PB-1:0]          thr_r;
  logic [CW-1:0]          cap_r;
  logic [CW-1:0]          head_r, head_nxt;
  logic [CW-1:0]          tail_r, tail_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          red_r, red_nxt;
  logic                   is_pop_r, is_pop_nxt;
  logic [CW-1:0]          base_r, base_nxt;
  logic [CW-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]          rd_off_r, rd_off_nxt;
  logic                   cv_r, cv_nxt;
  logic [CW-1:0]          cmp_ptr_r, cmp_ptr_nxt;
  logic [CW-1:0]          cmp_off_r, cmp_off_nxt;
  logic [ITEM_W-1:0]      hold_r, hold_nxt;
  logic [ITEM_W-1:0]      pick_r, pick_nxt;
  logic                   found_r, found_nxt;
  logic [CW-1:0]          rd_dst_r, rd_dst_nxt;
  logic [CW-1:0]          jr_r, jr_nxt;
  logic [CW-1:0]          wq_r, wq_nxt;
  logic                   wv_r, wv_nxt;
  logic                   out_strobe_r, out_strobe_nxt;
  rqpb_pkg::out_item_t    out_result_r, out_result_nxt;

  logic [CW-1:0]          cap_eff;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [ITEM_W-1:0]      ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [ITEM_W-1:0]      ram_rdata;

  function automatic logic [CW-1:0] ptr_inc(input logic [CW-1:0] p,
                                            input logic [CW-1:0] cap);
    logic [CW-1:0] s;
    s = p + CW'(1);
    return (s == cap) ? '0 : s;
  endfunction

  function automatic logic [CW-1:0] ptr_dec(input logic [CW-1:0] p,
                                            input logic [CW-1:0] cap);
    return (p == '0) ? (cap - CW'(1)) : (p - CW'(1));
  endfunction

  // A zero capacity acts as one, and anything above the built depth as the depth.
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CW'(1);
    end else if (cap_r > CW'(CAP_MAX)) begin
      cap_eff = CW'(CAP_MAX);
    end else begin
      cap_eff = cap_r;
    end
  end

  rqpb_ram #(
    .WIDTH (ITEM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    logic          fin;
    logic [ITEM_W-1:0] fin_data;
    logic          fin_found;

    fin            = 1'b0;
    fin_data       = '0;
    fin_found      = 1'b0;
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    red_nxt        = red_r;
    is_pop_nxt     = is_pop_r;
    base_nxt       = base_r;
    rd_ptr_nxt     = rd_ptr_r;
    rd_off_nxt     = rd_off_r;
    cv_nxt         = cv_r;
    cmp_ptr_nxt    = cmp_ptr_r;
    cmp_off_nxt    = cmp_off_r;
    hold_nxt       = hold_r;
    pick_nxt       = pick_r;
    found_nxt      = found_r;
    rd_dst_nxt     = rd_dst_r;
    jr_nxt         = jr_r;
    wq_nxt         = wq_r;
    wv_nxt         = wv_r;
    out_strobe_nxt = 1'b0;
    out_result_nxt = out_result_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_item.mode == rqpb_pkg::MODE_PUSH) begin
            if (count_r >= cap_eff) begin
              out_strobe_nxt = 1'b1;
              out_result_nxt = '{rqpb_pkg::STATUS_FULL, '0, '0, 1'b0, count_r};
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = AW'(tail_r);
              ram_wdata  = {in_item.in_priority, in_item.in_payload};
              count_nxt  = count_r + CW'(1);
              red_nxt    = tail_r + CW'(1);
              is_pop_nxt = 1'b0;
              state_nxt  = ST_NORM;
            end
          end else if (count_r == '0) begin
            out_strobe_nxt = 1'b1;
            out_result_nxt = '{rqpb_pkg::STATUS_EMPTY, '0, '0, 1'b0, count_r};
          end else begin
            red_nxt    = head_r;
            is_pop_nxt = 1'b1;
            found_nxt  = 1'b0;
            state_nxt  = ST_NORM;
          end
        end
      end

      // Bring a pointer below the capacity, which may have shrunk since it was set.
      ST_NORM: begin
        if (red_r >= cap_eff) begin
          red_nxt = red_r - cap_eff;
        end else if (is_pop_r) begin
          base_nxt   = red_r;
          rd_ptr_nxt = red_r;
          rd_off_nxt = '0;
          cv_nxt     = 1'b0;
          state_nxt  = ST_SRCH;
        end else begin
          tail_nxt       = red_r;
          out_strobe_nxt = 1'b1;
          out_result_nxt = '{rqpb_pkg::STATUS_DONE, '0, '0, 1'b0, count_r};
          state_nxt      = ST_IDLE;
        end
      end

      // Reads are issued one slot ahead of the compare on the returned data.
      ST_SRCH: begin
        ram_raddr   = AW'(rd_ptr_r);
        rd_ptr_nxt  = ptr_inc(rd_ptr_r, cap_eff);
        rd_off_nxt  = rd_off_r + CW'(1);
        cv_nxt      = 1'b1;
        cmp_ptr_nxt = rd_ptr_r;
        cmp_off_nxt = rd_off_r;
        if (cv_r) begin
          if (cmp_off_r == '0) begin
            hold_nxt = ram_rdata;
          end
          if ((count_r > CW'(1)) && (ram_rdata[ITEM_W-1 -: PB] >= thr_r)) begin
            found_nxt = 1'b1;
            pick_nxt  = ram_rdata;
            if (cmp_off_r == '0) begin
              fin       = 1'b1;
              fin_data  = ram_rdata;
              fin_found = 1'b1;
            end else begin
              rd_dst_nxt = cmp_ptr_r;
              jr_nxt     = cmp_off_r;
              wv_nxt     = 1'b0;
              state_nxt  = ST_SHIFT;
            end
          end else if (cmp_off_r == count_r - CW'(1)) begin
            fin       = 1'b1;
            fin_data  = (cmp_off_r == '0) ? ram_rdata : hold_r;
            fin_found = 1'b0;
          end
        end
      end

      // Move each older item one slot toward the picked one, newest first.
      ST_SHIFT: begin
        if (jr_r != '0) begin
          ram_raddr  = AW'(ptr_dec(rd_dst_r, cap_eff));
          wq_nxt     = rd_dst_r;
          wv_nxt     = 1'b1;
          rd_dst_nxt = ptr_dec(rd_dst_r, cap_eff);
          jr_nxt     = jr_r - CW'(1);
        end else begin
          wv_nxt = 1'b0;
        end
        if (wv_r) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(wq_r);
          ram_wdata = ram_rdata;
          if (jr_r == '0) begin
            fin       = 1'b1;
            fin_data  = pick_r;
            fin_found = 1'b1;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      head_nxt       = ptr_inc(base_r, cap_eff);
      count_nxt      = count_r - CW'(1);
      out_strobe_nxt = 1'b1;
      out_result_nxt = '{rqpb_pkg::STATUS_DONE, fin_data[ITEM_W-1 -: PB],
                         fin_data[rqpb_pkg::PAYLOAD_BITS-1:0], fin_found,
                         count_r - CW'(1)};
      state_nxt      = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      thr_r        <= PB'(128);
      cap_r        <= CW'(16);
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      is_pop_r     <= 1'b0;
      cv_r         <= 1'b0;
      found_r      <= 1'b0;
      wv_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      is_pop_r     <= is_pop_nxt;
      cv_r         <= cv_nxt;
      found_r      <= found_nxt;
      wv_r         <= wv_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        case (cfg_index)
          rqpb_pkg::REG_THRESHOLD: thr_r <= cfg_data[PB-1:0];
          rqpb_pkg::REG_CAP:       cap_r <= cfg_data[CW-1:0];
          default:                 thr_r <= thr_r;
        endcase
      end
    end
    red_r        <= red_nxt;
    base_r       <= base_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    rd_off_r     <= rd_off_nxt;
    cmp_ptr_r    <= cmp_ptr_nxt;
    cmp_off_r    <= cmp_off_nxt;
    hold_r       <= hold_nxt;
    pick_r       <= pick_nxt;
    rd_dst_r     <= rd_dst_nxt;
    jr_r         <= jr_nxt;
    wq_r         <= wq_nxt;
    out_result_r <= out_result_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

  // A result is only issued once the sequencer is back at rest.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result issued while busy");

  // Every request either answers at once or starts the sequencer.
  a_request_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("request dropped");

  // Failed requests carry no item.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_result.status != rqpb_pkg::STATUS_DONE)) |->
      (out_result.out_priority == '0 && out_result.out_payload == '0 &&
       !out_result.took_urgent))
    else $error("failed request carries item data");

  // Items are only moved forward after a priority hit.
  a_shift_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> found_r)
    else $error("shift without a priority hit");

endmodule

// ===== sv/rqpb_ram.sv =====
// ----------------------------------------------------------------------------
// rqpb_ram
// Generic single write port, single read port RAM with registered read.
// A read of the address being written returns the new data.
// ----------------------------------------------------------------------------
module rqpb_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
